// ----- design/bsfd_pkg.sv -----
// Shared types and constants for the byte-stuffed frame decoder.
// No dependencies; used by byte_stuffed_frame_decoder_unit.

package bsfd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned RSP_DATA_W = 24;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_CODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE = 2'd2;

   // Register values after reset.
   localparam logic [BYTE_W-1:0] START_CODE_RESET  = 8'd2;
   localparam logic [BYTE_W-1:0] STOP_CODE_RESET   = 8'd3;
   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RESET = 8'd16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_NO_START    = 3'd1,
      STATUS_NO_STOP     = 3'd2,
      STATUS_BARE_FLAG   = 3'd3,
      STATUS_ESC_AT_STOP = 3'd4,
      STATUS_BAD_ESCAPE  = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

endpackage

// ----- design/byte_stuffed_frame_decoder_unit.sv -----
// Byte-stuffed frame decoder: start/stop check, escape removal, end-of-frame status.
// Depends on bsfd_pkg for codes, widths and register indexes.
// A word accepted on req_ passes the input register, then the result register,
// before its result shows on rsp_; words that cause no result vanish there.
// Throughput: one word per cycle while rsp_tready does not stall the result register,
// set by the update of the frame state between the input and result registers.
// Reset (synchronous, active high) clears both valid bits, rearms the frame state
// and loads the start, stop and escape codes with 2, 3 and 16.

module byte_stuffed_frame_decoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Input words.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bsfd_pkg::BYTE_W-1:0]         req_tdata,  // frame_byte
   input  logic                                req_tlast,  // is_final
   // Result words.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] payload_byte, [10:8] frame_status, [18:11] payload_count, [23:19] zero
   output logic [bsfd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,  // result_kind
   // Configuration writes.
   input  logic                                csr_write_en,
   input  logic [bsfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bsfd_pkg::BYTE_W-1:0]         csr_wdata
);

   // Configuration registers.
   logic [bsfd_pkg::BYTE_W-1:0] start_code_ff, stop_code_ff, escape_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff  <= bsfd_pkg::START_CODE_RESET;
         stop_code_ff   <= bsfd_pkg::STOP_CODE_RESET;
         escape_code_ff <= bsfd_pkg::ESCAPE_CODE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bsfd_pkg::CSR_START_CODE:  start_code_ff  <= csr_wdata;
            bsfd_pkg::CSR_STOP_CODE:   stop_code_ff   <= csr_wdata;
            bsfd_pkg::CSR_ESCAPE_CODE: escape_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   logic                        in_valid_ff;
   logic [bsfd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        in_last_ff;

   // Result register.
   logic                          out_valid_ff;
   bsfd_pkg::kind_type            out_kind_ff,   out_kind_in;
   logic [bsfd_pkg::BYTE_W-1:0]   out_byte_ff,   out_byte_in;
   bsfd_pkg::status_type          out_status_ff, out_status_in;
   logic [bsfd_pkg::COUNT_W-1:0]  out_count_ff,  out_count_in;
   logic                          emit;

   // Frame state.
   logic                         at_frame_start_ff, at_frame_start_in;
   logic                         start_seen_ok_ff,  start_seen_ok_in;
   logic                         escape_pending_ff, escape_pending_in;
   bsfd_pkg::status_type         content_error_ff,  content_error_in;
   logic [bsfd_pkg::COUNT_W-1:0] decoded_count_ff,  decoded_count_in;

   logic out_open;
   logic work;

   assign out_open   = !out_valid_ff || rsp_tready;
   assign work       = in_valid_ff && out_open;
   assign req_tready = !in_valid_ff || out_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // One pass of the decoder over the registered byte.
   always_comb begin
      logic start_ok;
      logic is_special;
      logic decode;

      start_ok   = at_frame_start_ff ? (in_byte_ff == start_code_ff) : start_seen_ok_ff;
      is_special = (in_byte_ff == start_code_ff) || (in_byte_ff == stop_code_ff) ||
                   (in_byte_ff == escape_code_ff);
      decode     = 1'b0;

      at_frame_start_in = 1'b0;
      start_seen_ok_in  = start_ok;
      escape_pending_in = escape_pending_ff;
      content_error_in  = content_error_ff;
      decoded_count_in  = decoded_count_ff;

      emit          = 1'b0;
      out_kind_in   = bsfd_pkg::KIND_PAYLOAD;
      out_byte_in   = in_byte_ff;
      out_status_in = bsfd_pkg::STATUS_OK;
      out_count_in  = '0;

      if (in_last_ff) begin
         emit         = 1'b1;
         out_kind_in  = bsfd_pkg::KIND_STATUS;
         out_byte_in  = '0;
         out_count_in = decoded_count_ff;
         priority if (!start_ok) begin
            out_status_in = bsfd_pkg::STATUS_NO_START;
            out_count_in  = '0;
         end else if (in_byte_ff != stop_code_ff) begin
            out_status_in = bsfd_pkg::STATUS_NO_STOP;
            out_count_in  = '0;
         end else if (content_error_ff != bsfd_pkg::STATUS_OK) begin
            out_status_in = content_error_ff;
         end else if (escape_pending_ff) begin
            out_status_in = bsfd_pkg::STATUS_ESC_AT_STOP;
         end else begin
            out_status_in = bsfd_pkg::STATUS_OK;
         end
         // Rearm for the next frame.
         at_frame_start_in = 1'b1;
         start_seen_ok_in  = 1'b0;
         escape_pending_in = 1'b0;
         content_error_in  = bsfd_pkg::STATUS_OK;
         decoded_count_in  = '0;
      end else if (!at_frame_start_ff && start_ok &&
                   content_error_ff == bsfd_pkg::STATUS_OK) begin
         if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
            if (is_special) begin
               decode = 1'b1;
            end else begin
               content_error_in = bsfd_pkg::STATUS_BAD_ESCAPE;
            end
         end else if ((in_byte_ff == start_code_ff) || (in_byte_ff == stop_code_ff)) begin
            // A flag byte checks before the escape code does.
            content_error_in = bsfd_pkg::STATUS_BARE_FLAG;
         end else if (in_byte_ff == escape_code_ff) begin
            escape_pending_in = 1'b1;
         end else begin
            decode = 1'b1;
         end
      end

      if (decode) begin
         emit = 1'b1;
         if (decoded_count_ff != bsfd_pkg::COUNT_MAX) begin
            decoded_count_in = decoded_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_frame_start_ff <= 1'b1;
         start_seen_ok_ff  <= 1'b0;
         escape_pending_ff <= 1'b0;
         content_error_ff  <= bsfd_pkg::STATUS_OK;
         decoded_count_ff  <= '0;
      end else if (work) begin
         at_frame_start_ff <= at_frame_start_in;
         start_seen_ok_ff  <= start_seen_ok_in;
         escape_pending_ff <= escape_pending_in;
         content_error_ff  <= content_error_in;
         decoded_count_ff  <= decoded_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_open) begin
         out_valid_ff <= work && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (work && emit) begin
         out_kind_ff   <= out_kind_in;
         out_byte_ff   <= out_byte_in;
         out_status_ff <= out_status_in;
         out_count_ff  <= out_count_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {{(bsfd_pkg::RSP_DATA_W - bsfd_pkg::BYTE_W - bsfd_pkg::STATUS_W
                          - bsfd_pkg::COUNT_W){1'b0}},
                        out_count_ff, out_status_ff, out_byte_ff};

   // A status word for a missing start or stop flag reports no payload.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == bsfd_pkg::KIND_STATUS &&
      (out_status_ff == bsfd_pkg::STATUS_NO_START || out_status_ff == bsfd_pkg::STATUS_NO_STOP)
      |-> out_count_ff == '0)
      else $error("status word without start or stop carries a nonzero count");

   // Payload words carry zero status and count.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == bsfd_pkg::KIND_PAYLOAD
      |-> out_status_ff == bsfd_pkg::STATUS_OK && out_count_ff == '0)
      else $error("payload word carries status or count");

   // The last byte of a frame rearms the decoder.
   assert property (@(posedge clock) disable iff (reset)
      work && in_last_ff |=> at_frame_start_ff && !escape_pending_ff &&
      content_error_ff == bsfd_pkg::STATUS_OK && decoded_count_ff == '0)
      else $error("decoder not rearmed after the last byte of a frame");

   // Only the bare-flag and bad-escape errors are latched during content.
   assert property (@(posedge clock) disable iff (reset)
      content_error_ff == bsfd_pkg::STATUS_OK ||
      content_error_ff == bsfd_pkg::STATUS_BARE_FLAG ||
      content_error_ff == bsfd_pkg::STATUS_BAD_ESCAPE)
      else $error("unexpected latched content error");

endmodule

// ----- dv/frame_decode_checker.sv -----
`timescale 1ns / 100ps
// Watches the word, result and register ports of the byte-stuffed frame decoder,
// predicts every result word and compares it field by field. Depends on bsfd_pkg.

module frame_decode_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [bsfd_pkg::BYTE_W-1:0]     req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [bsfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            csr_write_en,
   input  logic [bsfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsfd_pkg::BYTE_W-1:0]     csr_wdata,
   output int                              mismatch_count,
   output int                              awaited_count
);

   typedef struct {
      bsfd_pkg::kind_type                kind;
      logic [bsfd_pkg::BYTE_W-1:0]       data;
      bsfd_pkg::status_type              status;
      logic [bsfd_pkg::COUNT_W-1:0]      count;
   } decoded_word_type;

   decoded_word_type  awaited[$];
   decoded_word_type  head;

   logic [bsfd_pkg::BYTE_W-1:0]  start_code;
   logic [bsfd_pkg::BYTE_W-1:0]  stop_code;
   logic [bsfd_pkg::BYTE_W-1:0]  escape_code;
   logic                         at_start;
   logic                         start_ok;
   logic                         esc_pending;
   bsfd_pkg::status_type         content_err;
   logic [bsfd_pkg::COUNT_W-1:0] byte_count;

   function automatic void rearm_frame();
      at_start    = 1'b1;
      start_ok    = 1'b0;
      esc_pending = 1'b0;
      content_err = bsfd_pkg::STATUS_OK;
      byte_count  = '0;
   endfunction

   // Advances the frame state by one raw byte and queues the word it produces.
   function automatic void decode_byte(input logic [bsfd_pkg::BYTE_W-1:0] b,
                                       input logic fin);
      decoded_word_type w;
      logic first;
      first = at_start;
      if (first) begin
         start_ok = (b == start_code);
         at_start = 1'b0;
      end
      if (fin) begin
         w.kind  = bsfd_pkg::KIND_STATUS;
         w.data  = '0;
         w.count = byte_count;
         if (!start_ok) begin
            w.status = bsfd_pkg::STATUS_NO_START;
            w.count  = '0;
         end else if (b != stop_code) begin
            w.status = bsfd_pkg::STATUS_NO_STOP;
            w.count  = '0;
         end else if (content_err != bsfd_pkg::STATUS_OK) begin
            w.status = content_err;
         end else if (esc_pending) begin
            w.status = bsfd_pkg::STATUS_ESC_AT_STOP;
         end else begin
            w.status = bsfd_pkg::STATUS_OK;
         end
         awaited.push_back(w);
         rearm_frame();
         return;
      end
      if (first || !start_ok || content_err != bsfd_pkg::STATUS_OK)
         return;
      if (esc_pending) begin
         esc_pending = 1'b0;
         if (!(b == start_code || b == stop_code || b == escape_code)) begin
            content_err = bsfd_pkg::STATUS_BAD_ESCAPE;
            return;
         end
      end else if (b == start_code || b == stop_code) begin
         content_err = bsfd_pkg::STATUS_BARE_FLAG;
         return;
      end else if (b == escape_code) begin
         esc_pending = 1'b1;
         return;
      end
      if (byte_count != bsfd_pkg::COUNT_MAX)
         byte_count++;
      w.kind   = bsfd_pkg::KIND_PAYLOAD;
      w.data   = b;
      w.status = bsfd_pkg::STATUS_OK;
      w.count  = '0;
      awaited.push_back(w);
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // All ports are sampled at the rising edge, before any update of that edge lands.
   always @(posedge clock) begin
      if (reset) begin
         start_code     = bsfd_pkg::START_CODE_RESET;
         stop_code      = bsfd_pkg::STOP_CODE_RESET;
         escape_code    = bsfd_pkg::ESCAPE_CODE_RESET;
         mismatch_count = 0;
         rearm_frame();
         awaited.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               $display("%0t: unexpected result word, expected nothing, %s %b %h",
                        $time, "actual tuser/tdata", rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               head = awaited.pop_front();
               check_field("result_kind", head.kind, rsp_tuser);
               check_field("payload_byte", head.data, rsp_tdata[7:0]);
               check_field("frame_status", head.status, rsp_tdata[10:8]);
               check_field("payload_count", head.count, rsp_tdata[18:11]);
               check_field("tdata padding", 0, rsp_tdata[23:19]);
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               bsfd_pkg::CSR_START_CODE:  start_code  = csr_wdata;
               bsfd_pkg::CSR_STOP_CODE:   stop_code   = csr_wdata;
               bsfd_pkg::CSR_ESCAPE_CODE: escape_code = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tlast);
      end
      awaited_count = awaited.size();
   end

endmodule

// ----- dv/byte_stuffed_frame_decoder_unit_test.sv -----
`timescale 1ns / 100ps
// Top of the frame decoder test: clock, reset, framed byte stimulus and register phases.
// Depends on bsfd_pkg, byte_stuffed_frame_decoder_unit and frame_decode_checker.

module byte_stuffed_frame_decoder_unit_test;

   logic                            clock        = 1'b0;
   logic                            reset        = 1'b1;
   logic                            req_tvalid   = 1'b0;
   logic                            req_tready;
   logic [bsfd_pkg::BYTE_W-1:0]     req_tdata    = '0;
   logic                            req_tlast    = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready   = 1'b0;
   logic [bsfd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_write_en = 1'b0;
   logic [bsfd_pkg::CSR_IDX_W-1:0]  csr_index    = '0;
   logic [bsfd_pkg::BYTE_W-1:0]     csr_wdata    = '0;

   int                              mismatch_count;
   int                              awaited_count;

   // Codes currently loaded, used to shape the frames.
   logic [bsfd_pkg::BYTE_W-1:0]     start_code  = bsfd_pkg::START_CODE_RESET;
   logic [bsfd_pkg::BYTE_W-1:0]     stop_code   = bsfd_pkg::STOP_CODE_RESET;
   logic [bsfd_pkg::BYTE_W-1:0]     escape_code = bsfd_pkg::ESCAPE_CODE_RESET;
   logic [bsfd_pkg::BYTE_W-1:0]     frame_bytes[$];
   bit                              steady = 1'b0;
   int                              words_sent = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   byte_stuffed_frame_decoder_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   frame_decode_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [bsfd_pkg::BYTE_W-1:0] rand_byte();
      int r;
      r = $urandom_range(0, 255);
      return r[bsfd_pkg::BYTE_W-1:0];
   endfunction

   function automatic logic [bsfd_pkg::BYTE_W-1:0] pick_content();
      case ($urandom_range(0, 9))
         0:       return start_code;
         1:       return stop_code;
         2:       return escape_code;
         default: return rand_byte();
      endcase
   endfunction

   // Returns at the edge where the word is taken, with tvalid still high.
   task automatic send_word(input logic [bsfd_pkg::BYTE_W-1:0] b, input logic fin);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i])
         send_word(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // Builds a properly stuffed frame, then most of the time leaves it intact and
   // otherwise breaks it in one way, or replaces it by raw noise.
   task automatic build_frame(input int content_len, input bit allow_faults);
      int mode;
      int pos;
      logic [bsfd_pkg::BYTE_W-1:0] b;
      frame_bytes.delete();
      mode = allow_faults ? $urandom_range(0, 99) : 99;
      if (mode < 8) begin
         repeat ($urandom_range(1, 8)) frame_bytes.push_back(pick_content());
         return;
      end
      frame_bytes.push_back(start_code);
      repeat (content_len) begin
         b = pick_content();
         if (b == start_code || b == stop_code || b == escape_code)
            frame_bytes.push_back(escape_code);
         frame_bytes.push_back(b);
      end
      frame_bytes.push_back(stop_code);
      pos = $urandom_range(1, frame_bytes.size() - 1);
      if (mode < 14)
         frame_bytes[0] = rand_byte();
      else if (mode < 20)
         frame_bytes[frame_bytes.size() - 1] = rand_byte();
      else if (mode < 26)
         frame_bytes.insert(pos, $urandom_range(0, 1) ? start_code : stop_code);
      else if (mode < 32) begin
         frame_bytes.insert(pos, rand_byte());
         frame_bytes.insert(pos, escape_code);
      end else if (mode < 37)
         frame_bytes.insert(frame_bytes.size() - 1, escape_code);
   endtask

   task automatic load_codes(input logic [bsfd_pkg::BYTE_W-1:0] s,
                             input logic [bsfd_pkg::BYTE_W-1:0] p,
                             input logic [bsfd_pkg::BYTE_W-1:0] e);
      csr_write_en <= 1'b1;
      csr_index    <= bsfd_pkg::CSR_START_CODE;
      csr_wdata    <= s;
      @(posedge clock);
      csr_index    <= bsfd_pkg::CSR_STOP_CODE;
      csr_wdata    <= p;
      @(posedge clock);
      csr_index    <= bsfd_pkg::CSR_ESCAPE_CODE;
      csr_wdata    <= e;
      @(posedge clock);
      csr_write_en <= 1'b0;
      start_code  = s;
      stop_code   = p;
      escape_code = e;
   endtask

   // Waits until every expected word has come out and the pipeline has drained.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : ready_pattern
      int hold;
      bit open;
      hold = 0;
      forever begin
         @(posedge clock);
         if (steady)
            rsp_tready <= 1'b1;
         else if (hold > 0)
            hold--;
         else begin
            open = ($urandom_range(0, 3) != 0);
            hold = open ? $urandom_range(0, 6) : gap_length();
            rsp_tready <= open;
         end
      end
   end

   initial begin : stimulus
      int target;
      int len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 9; p++) begin
         if (p > 0) begin
            case (p)
               1:       load_codes(8'h00, 8'hFF, 8'h80);
               2:       load_codes(8'hFF, 8'h00, 8'h01);
               3:       load_codes(8'h7E, 8'h7E, 8'h7E);
               4:       load_codes(8'h55, 8'hAA, 8'h55);
               5:       load_codes(8'h10, 8'h10, 8'h20);
               6:       load_codes(8'h30, 8'h40, 8'h40);
               default: load_codes(rand_byte(), rand_byte(), rand_byte());
            endcase
         end
         steady = (p % 3 == 2);

         if (p == 0) begin
            // Empty frame, payload extremes, escaped codes, escape left at the stop,
            // bad escape, bare flag, no start, no stop, single stop byte.
            frame_bytes = {bsfd_pkg::START_CODE_RESET, bsfd_pkg::STOP_CODE_RESET};
            send_frame();
            frame_bytes = {bsfd_pkg::START_CODE_RESET, 8'h00, 8'hFF,
                           bsfd_pkg::STOP_CODE_RESET};
            send_frame();
            frame_bytes = {bsfd_pkg::START_CODE_RESET, bsfd_pkg::ESCAPE_CODE_RESET,
                           bsfd_pkg::START_CODE_RESET, bsfd_pkg::ESCAPE_CODE_RESET,
                           bsfd_pkg::ESCAPE_CODE_RESET, bsfd_pkg::STOP_CODE_RESET};
            send_frame();
            frame_bytes = {bsfd_pkg::START_CODE_RESET, 8'h41, bsfd_pkg::ESCAPE_CODE_RESET,
                           bsfd_pkg::STOP_CODE_RESET};
            send_frame();
            frame_bytes = {bsfd_pkg::START_CODE_RESET, bsfd_pkg::ESCAPE_CODE_RESET, 8'h55,
                           bsfd_pkg::STOP_CODE_RESET};
            send_frame();
            frame_bytes = {bsfd_pkg::START_CODE_RESET, bsfd_pkg::START_CODE_RESET,
                           bsfd_pkg::STOP_CODE_RESET};
            send_frame();
            frame_bytes = {8'h99, bsfd_pkg::STOP_CODE_RESET};
            send_frame();
            frame_bytes = {bsfd_pkg::START_CODE_RESET, 8'h42};
            send_frame();
            frame_bytes = {bsfd_pkg::STOP_CODE_RESET};
            send_frame();
            // A long clean frame drives the payload count into saturation.
            build_frame(262, 1'b0);
            send_frame();
         end

         // A lone start byte; it closes cleanly when start and stop codes match.
         frame_bytes = {start_code};
         send_frame();

         target = words_sent + 35;
         while (words_sent < target) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            build_frame(len, 1'b1);
            send_frame();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
